FILE: rtl/rpse_pkg.sv
// Shared types, constants and term tables for the RGB polynomial spectral evaluator.
package rpse_pkg;

    localparam int TERMS          = 36;
    localparam int DEF_BANDS      = 512;
    localparam int DEF_PIXEL_BITS = 8;

    localparam int BAND_W     = 9;
    localparam int TERM_W     = 6;
    localparam int COEF_W     = 32;
    localparam int VALUE_W    = 32;
    localparam int FEAT_W     = 17;
    localparam int OPA_W      = COEF_W + 1;
    localparam int OPB_W      = FEAT_W + 1;
    localparam int PROD_W     = OPA_W + OPB_W;
    localparam int ACC_W      = 58;
    localparam int FRAC_DROP  = 24;
    localparam int Q_W        = ACC_W - FRAC_DROP;
    localparam int CALC_W     = BAND_W + 7;
    localparam int BAND_CMP_W = 11;

    localparam int FIRST_DERIVED = 5;
    localparam int NUM_STORED    = TERMS - FIRST_DERIVED;
    localparam int STORE_IDX_W   = $clog2(NUM_STORED);
    localparam int DRAIN_CYCLES  = 3;

    localparam int M_DATA_W = 48;
    localparam int M_PAD_W  = M_DATA_W - VALUE_W - BAND_W;

    localparam logic [FEAT_W-1:0] ONE_Q16    = FEAT_W'(65536);
    localparam logic [ACC_W-1:0]  ROUND_HALF = ACC_W'(1) << (FRAC_DROP - 1);
    localparam logic [VALUE_W-1:0] VALUE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
    localparam logic [VALUE_W-1:0] VALUE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_EVAL  = 1'b1;

    localparam logic [1:0] CH_R = 2'd0;
    localparam logic [1:0] CH_G = 2'd1;
    localparam logic [1:0] CH_B = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FEAT,
        ST_MAC,
        ST_DRAIN,
        ST_ROUND
    } state_t;

    // Control from the sequencer to the datapath.
    typedef struct packed {
        logic              start;
        logic              issue_valid;
        logic              issue_mac;
        logic [TERM_W-1:0] issue_term;
        logic              band_ok;
    } ctrl_t;

    // Lower-degree term that a derived term is built from.
    function automatic logic [TERM_W-1:0] src_term(input logic [TERM_W-1:0] t);
        logic [TERM_W-1:0] s;
        case (t)
            6'd5, 6'd6, 6'd7:    s = 6'd2;
            6'd8, 6'd9:          s = 6'd3;
            6'd10:               s = 6'd4;
            6'd11, 6'd12, 6'd13: s = 6'd5;
            6'd14, 6'd15:        s = 6'd6;
            6'd16:               s = 6'd7;
            6'd17, 6'd18:        s = 6'd8;
            6'd19:               s = 6'd9;
            6'd20:               s = 6'd10;
            6'd21, 6'd22, 6'd23: s = 6'd11;
            6'd24, 6'd25:        s = 6'd12;
            6'd26:               s = 6'd13;
            6'd27, 6'd28:        s = 6'd14;
            6'd29:               s = 6'd15;
            6'd30:               s = 6'd16;
            6'd31, 6'd32:        s = 6'd17;
            6'd33:               s = 6'd18;
            6'd34:               s = 6'd19;
            6'd35:               s = 6'd20;
            default:             s = 6'd2;
        endcase
        return s;
    endfunction

    // Color channel that multiplies the source term.
    function automatic logic [1:0] src_chan(input logic [TERM_W-1:0] t);
        logic [1:0] c;
        case (t)
            6'd5, 6'd11, 6'd21:                        c = CH_R;
            6'd6, 6'd8, 6'd12, 6'd14, 6'd17, 6'd22,
            6'd24, 6'd27, 6'd31:                       c = CH_G;
            default:                                   c = CH_B;
        endcase
        return c;
    endfunction

    // Coefficient address band * TERMS + term, as 32*band + 4*band + term.
    function automatic logic [CALC_W-1:0] coef_addr(input logic [BAND_W-1:0] band,
                                                     input logic [TERM_W-1:0] term);
        logic [CALC_W-1:0] b;
        b = CALC_W'(band);
        return (b << 5) + (b << 2) + CALC_W'(term);
    endfunction

endpackage

FILE: rtl/rpse_coef_ram.sv
// Single-port-write, single-port-read coefficient memory with registered read data.
module rpse_coef_ram
    import rpse_pkg::*;
#(
    parameter int DEPTH  = DEF_BANDS * TERMS,
    parameter int ADDR_W = $clog2(DEPTH)
)
(
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [COEF_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [COEF_W-1:0] rdata
);

    logic [COEF_W-1:0] mem_reg [DEPTH];
    logic [COEF_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/rpse_seq.sv
// Sequencer: walks the feature terms, then the multiply-accumulate terms, then drains and rounds.
module rpse_seq
    import rpse_pkg::*;
#(
    parameter int BANDS = DEF_BANDS
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic              cmd,
    input  logic [BAND_W-1:0] band,
    input  logic              out_free,
    output logic              ready,
    output logic              load_out,
    output ctrl_t             ctrl,
    output logic [CALC_W-1:0] raddr
);

    state_t            state_reg, state_next;
    logic [TERM_W-1:0] cnt_reg, cnt_next;
    logic [CALC_W-1:0] base_reg;
    logic              band_ok_reg;
    logic              band_ok;
    logic              start;

    assign band_ok = BAND_CMP_W'(band) < BAND_CMP_W'(BANDS);
    assign start   = accept && (cmd == CMD_EVAL);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Out-of-range bands read from address zero; their products are not summed.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            base_reg    <= band_ok ? coef_addr(band, '0) : '0;
            band_ok_reg <= band_ok;
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        cnt_next          = cnt_reg;
        ready             = 1'b0;
        load_out          = 1'b0;
        ctrl.start        = 1'b0;
        ctrl.issue_valid  = 1'b0;
        ctrl.issue_mac    = 1'b0;
        ctrl.issue_term   = cnt_reg;
        ctrl.band_ok      = band_ok_reg;
        case (state_reg)
            ST_IDLE:
            begin
                ready      = 1'b1;
                ctrl.start = start;
                if (start)
                begin
                    state_next = ST_FEAT;
                    cnt_next   = TERM_W'(FIRST_DERIVED);
                end
            end
            ST_FEAT:
            begin
                ctrl.issue_valid = 1'b1;
                if (cnt_reg == TERM_W'(TERMS - 1))
                begin
                    state_next = ST_MAC;
                    cnt_next   = '0;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_MAC:
            begin
                ctrl.issue_valid = 1'b1;
                ctrl.issue_mac   = 1'b1;
                if (cnt_reg == TERM_W'(TERMS - 1))
                begin
                    state_next = ST_DRAIN;
                    cnt_next   = '0;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                if (cnt_reg == TERM_W'(DRAIN_CYCLES - 1))
                begin
                    state_next = ST_ROUND;
                    cnt_next   = '0;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_ROUND:
            begin
                if (out_free)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign raddr = base_reg + CALC_W'(cnt_reg);

endmodule

FILE: rtl/rpse_datapath.sv
// Shared multiplier pipeline: builds the monomial features, then accumulates coef * feature.
module rpse_datapath
    import rpse_pkg::*;
#(
    parameter int PIXEL_BITS = DEF_PIXEL_BITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  ctrl_t                 ctrl,
    input  logic [PIXEL_BITS-1:0] red,
    input  logic [PIXEL_BITS-1:0] green,
    input  logic [PIXEL_BITS-1:0] blue,
    input  logic [COEF_W-1:0]     coef_rdata,
    output logic [VALUE_W-1:0]    value,
    output logic                  saturated
);

    localparam int PIX_SHIFT = 16 - PIXEL_BITS;

    logic [FEAT_W-1:0] ch_reg   [3];
    logic [FEAT_W-1:0] feat_reg [NUM_STORED];

    logic              v1_reg, v2_reg, v3_reg;
    logic              mac1_reg, mac2_reg, mac3_reg;
    logic [TERM_W-1:0] t1_reg, t2_reg, t3_reg;

    logic signed [OPA_W-1:0]  opa_reg;
    logic signed [OPB_W-1:0]  opb_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;

    logic [TERM_W-1:0]      sel_idx;
    logic [TERM_W-1:0]      sel_off;
    logic [TERM_W-1:0]      wr_off;
    logic [FEAT_W-1:0]      feat_val;
    logic [FEAT_W-1:0]      chan_val;
    logic [OPA_W-1:0]       opa_next;
    logic [OPB_W-1:0]       opb_next;
    logic [ACC_W-1:0]       rounded;
    logic [Q_W-1:0]         q_wide;
    logic                   overflow;

    // A mac step reads its own term; a feature step reads the term it extends.
    assign sel_idx = mac1_reg ? t1_reg : src_term(t1_reg);
    assign sel_off = sel_idx - TERM_W'(FIRST_DERIVED);
    assign wr_off  = t3_reg - TERM_W'(FIRST_DERIVED);

    always_comb
    begin
        if (sel_idx < TERM_W'(2))
        begin
            feat_val = ONE_Q16;
        end
        else if (sel_idx < TERM_W'(FIRST_DERIVED))
        begin
            feat_val = ch_reg[2'(sel_idx - TERM_W'(2))];
        end
        else
        begin
            feat_val = feat_reg[sel_off[STORE_IDX_W-1:0]];
        end
    end

    assign chan_val = ch_reg[src_chan(t1_reg)];
    assign opa_next = mac1_reg ? {coef_rdata[COEF_W-1], coef_rdata}
                               : OPA_W'(feat_val);
    assign opb_next = mac1_reg ? OPB_W'(feat_val) : OPB_W'(chan_val);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= ctrl.issue_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        mac1_reg <= ctrl.issue_mac;
        t1_reg   <= ctrl.issue_term;
        mac2_reg <= mac1_reg;
        t2_reg   <= t1_reg;
        mac3_reg <= mac2_reg;
        t3_reg   <= t2_reg;
        opa_reg  <= signed'(opa_next);
        opb_reg  <= signed'(opb_next);
        prod_reg <= opa_reg * opb_reg;

        if (ctrl.start)
        begin
            ch_reg[0] <= FEAT_W'(red) << PIX_SHIFT;
            ch_reg[1] <= FEAT_W'(green) << PIX_SHIFT;
            ch_reg[2] <= FEAT_W'(blue) << PIX_SHIFT;
        end

        if (ctrl.start)
        begin
            acc_reg <= '0;
        end
        else if (v3_reg && mac3_reg && ctrl.band_ok)
        begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end

        // Derived features are Q1.16 products truncated back to Q1.16.
        if (v3_reg && !mac3_reg)
        begin
            feat_reg[wr_off[STORE_IDX_W-1:0]] <= prod_reg[FEAT_W+15:16];
        end
    end

    // Round half up from Q.40 to Q.16, then clip to 32 bits.
    assign rounded  = acc_reg + ROUND_HALF;
    assign q_wide   = rounded[ACC_W-1:FRAC_DROP];
    assign overflow = !((&q_wide[Q_W-1:VALUE_W-1]) || !(|q_wide[Q_W-1:VALUE_W-1]));
    assign value    = overflow ? (q_wide[Q_W-1] ? VALUE_MIN : VALUE_MAX)
                               : q_wide[VALUE_W-1:0];
    assign saturated = overflow;

endmodule

FILE: rtl/rgb_poly4_spectrum_eval.sv
// Top level of the degree-4 RGB polynomial spectral evaluator.
//
// Input stream (s_axis): tuser carries the command, 0 writes one coefficient,
// 1 evaluates a pixel at a band. tdata carries red, green, blue, band, term and
// the Q8.24 coefficient. A write stores the coefficient at (band, term) in the
// word's accept cycle and produces no output; writes may follow one per cycle while idle.
// An evaluation makes one output word on m_axis: the band and the saturated
// Q16.16 sum, with tuser set when the sum was clipped.
// An evaluation runs on one multiplier: it builds the 31 higher monomials,
// multiply-accumulates the band's 36 coefficients, drains the multiplier
// pipeline and rounds. A new word is taken only once the result has gone
// to the output register, so evaluations do not overlap.
// s_axis_tready is low while an evaluation is in progress.
// The result waits in an output register; if the receiver stalls, the block
// finishes the next evaluation and holds it until that register is free.
// Reset clears the control state only; coefficients are undefined until written.
module rgb_poly4_spectrum_eval
    import rpse_pkg::*;
#(
    parameter  int BANDS      = DEF_BANDS,
    parameter  int PIXEL_BITS = DEF_PIXEL_BITS,
    localparam int S_DATA_W   = ((3 * PIXEL_BITS + BAND_W + TERM_W + COEF_W + 7) / 8) * 8
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // red, green, blue, band, term, coef_value, zero fill
    input  logic [S_DATA_W-1:0] s_axis_tdata,
    // cmd
    input  logic                s_axis_tuser,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // band_out, spectral_value, zero fill
    output logic [M_DATA_W-1:0] m_axis_tdata,
    // saturated
    output logic                m_axis_tuser
);

    localparam int DEPTH    = BANDS * TERMS;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int GREEN_LO = PIXEL_BITS;
    localparam int BLUE_LO  = 2 * PIXEL_BITS;
    localparam int BAND_LO  = 3 * PIXEL_BITS;
    localparam int TERM_LO  = BAND_LO + BAND_W;
    localparam int COEF_LO  = TERM_LO + TERM_W;

    logic [PIXEL_BITS-1:0] red, green, blue;
    logic [BAND_W-1:0]     band;
    logic [TERM_W-1:0]     term;
    logic [COEF_W-1:0]     coef_value;

    logic              accept;
    logic              ready;
    logic              load_out;
    logic              out_free;
    ctrl_t             ctrl;
    logic [CALC_W-1:0] raddr_full;
    logic [CALC_W-1:0] waddr_full;
    logic              ram_we;
    logic [COEF_W-1:0] coef_rdata;
    logic [VALUE_W-1:0] value;
    logic               saturated;

    logic               out_valid_reg, out_valid_next;
    logic [BAND_W-1:0]  band_hold_reg;
    logic [BAND_W-1:0]  out_band_reg;
    logic [VALUE_W-1:0] out_value_reg;
    logic               out_sat_reg;

    assign red        = s_axis_tdata[PIXEL_BITS-1:0];
    assign green      = s_axis_tdata[GREEN_LO +: PIXEL_BITS];
    assign blue       = s_axis_tdata[BLUE_LO +: PIXEL_BITS];
    assign band       = s_axis_tdata[BAND_LO +: BAND_W];
    assign term       = s_axis_tdata[TERM_LO +: TERM_W];
    assign coef_value = s_axis_tdata[COEF_LO +: COEF_W];

    assign s_axis_tready = ready;
    assign accept        = s_axis_tvalid && ready;
    assign out_free      = !out_valid_reg || m_axis_tready;

    // Writes outside the band or term range are dropped.
    assign waddr_full = coef_addr(band, term);
    assign ram_we     = accept && (s_axis_tuser == CMD_WRITE)
                        && (term < TERM_W'(TERMS))
                        && (BAND_CMP_W'(band) < BAND_CMP_W'(BANDS));

    rpse_seq #(
        .BANDS (BANDS)
    ) u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .cmd      (s_axis_tuser),
        .band     (band),
        .out_free (out_free),
        .ready    (ready),
        .load_out (load_out),
        .ctrl     (ctrl),
        .raddr    (raddr_full)
    );

    rpse_coef_ram #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_coef_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (waddr_full[ADDR_W-1:0]),
        .wdata (coef_value),
        .raddr (raddr_full[ADDR_W-1:0]),
        .rdata (coef_rdata)
    );

    rpse_datapath #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .red        (red),
        .green      (green),
        .blue       (blue),
        .coef_rdata (coef_rdata),
        .value      (value),
        .saturated  (saturated)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            band_hold_reg <= band;
        end
        if (load_out)
        begin
            out_band_reg  <= band_hold_reg;
            out_value_reg <= value;
            out_sat_reg   <= saturated;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{M_PAD_W{1'b0}}, out_value_reg, out_band_reg};
    assign m_axis_tuser  = out_sat_reg;

    // A finished result never overwrites one the receiver has not taken.
    a_load_into_free_slot: assert property (
        @(posedge clk) disable iff (!rst_n)
        load_out |-> (!out_valid_reg || m_axis_tready))
        else $error("result loaded over a pending output word");

    // An accepted evaluation keeps the input closed on the next cycle.
    a_eval_blocks_input: assert property (
        @(posedge clk) disable iff (!rst_n)
        (accept && (s_axis_tuser == CMD_EVAL)) |=> !s_axis_tready)
        else $error("input ready right after an evaluation was accepted");

    // The coefficient memory is written only in the cycle a write word is taken.
    a_write_only_on_accept: assert property (
        @(posedge clk) disable iff (!rst_n)
        ram_we |-> (accept && (s_axis_tuser == CMD_WRITE) && !ctrl.issue_valid))
        else $error("coefficient write outside an accepted write word");

endmodule

FILE: dv/testbench.sv
// Self-checking testbench for rgb_poly4_spectrum_eval: coefficient writes and band evaluations.
module testbench
    import rpse_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int S_DATA_W = ((3 * DEF_PIXEL_BITS + BAND_W + TERM_W + COEF_W + 7) / 8) * 8;
    localparam logic [DEF_PIXEL_BITS-1:0] PIX_MAX = '1;
    localparam int TERM_MAX     = (1 << TERM_W) - 1;
    localparam int HOLD_CYCLES  = 400;
    localparam int END_CYCLES   = 150;
    localparam int PHASE_WORDS  = 370;

    localparam logic [COEF_W-1:0] COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
    localparam logic [COEF_W-1:0] COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};

    // Each monomial of degree two and up is a lower term times one channel.
    localparam int MONO_BASE [TERMS] = '{
        0, 0, 0, 0, 0,
        2, 2, 2, 3, 3, 4,
        5, 5, 5, 6, 6, 7, 8, 8, 9, 10,
        11, 11, 11, 12, 12, 13, 14, 14, 15, 16, 17, 17, 18, 19, 20
    };
    localparam logic [1:0] MONO_CHAN [TERMS] = '{
        CH_R, CH_R, CH_R, CH_R, CH_R,
        CH_R, CH_G, CH_B, CH_G, CH_B, CH_B,
        CH_R, CH_G, CH_B, CH_G, CH_B, CH_B, CH_G, CH_B, CH_B, CH_B,
        CH_R, CH_G, CH_B, CH_G, CH_B, CH_B, CH_G, CH_B, CH_B, CH_B,
        CH_G, CH_B, CH_B, CH_B, CH_B
    };

    typedef struct {
        logic [BAND_W-1:0]  band;
        logic [VALUE_W-1:0] value;
        logic               sat;
    } spectral_result_t;

    class spectrum_scoreboard;
        logic [COEF_W-1:0] coef_mem [TERMS * DEF_BANDS];
        spectral_result_t  pending_results [$];
        int unsigned       mismatches;
        int unsigned       writes_taken;
        int unsigned       writes_dropped;
        int unsigned       evals_taken;
        int unsigned       results_checked;

        function spectral_result_t reconstruct(logic [BAND_W-1:0] band,
                                               logic [DEF_PIXEL_BITS-1:0] r,
                                               logic [DEF_PIXEL_BITS-1:0] g,
                                               logic [DEF_PIXEL_BITS-1:0] b);
            logic [FEAT_W-1:0]   chan_q16 [3];
            logic [FEAT_W-1:0]   feat [TERMS];
            logic [2*FEAT_W-1:0] prod;
            longint              acc;
            longint              rounded;
            spectral_result_t    res;
            chan_q16[CH_R] = FEAT_W'(r) << (16 - DEF_PIXEL_BITS);
            chan_q16[CH_G] = FEAT_W'(g) << (16 - DEF_PIXEL_BITS);
            chan_q16[CH_B] = FEAT_W'(b) << (16 - DEF_PIXEL_BITS);
            feat[0] = ONE_Q16;
            feat[1] = ONE_Q16;
            feat[2] = chan_q16[CH_R];
            feat[3] = chan_q16[CH_G];
            feat[4] = chan_q16[CH_B];
            for (int t = FIRST_DERIVED; t < TERMS; t++)
            begin
                prod    = feat[MONO_BASE[t]] * chan_q16[MONO_CHAN[t]];
                feat[t] = prod[16 +: FEAT_W];
            end
            acc = 0;
            for (int t = 0; t < TERMS; t++)
                acc += longint'($signed(coef_mem[int'(band) * TERMS + t]))
                       * longint'({1'b0, feat[t]});
            // Q.40 down to Q16.16, rounding half up.
            rounded = (acc + (longint'(1) <<< 23)) >>> 24;
            res.band = band;
            res.sat  = 1'b0;
            if (rounded > 64'sd2147483647)
            begin
                rounded = 64'sd2147483647;
                res.sat = 1'b1;
            end
            else if (rounded < -64'sd2147483648)
            begin
                rounded = -64'sd2147483648;
                res.sat = 1'b1;
            end
            res.value = VALUE_W'(rounded);
            return res;
        endfunction

        function void note_word(logic cmd, logic [DEF_PIXEL_BITS-1:0] r,
                                logic [DEF_PIXEL_BITS-1:0] g, logic [DEF_PIXEL_BITS-1:0] b,
                                logic [BAND_W-1:0] band, logic [TERM_W-1:0] term,
                                logic [COEF_W-1:0] coef);
            if (cmd == CMD_WRITE)
            begin
                if (term < TERMS)
                begin
                    coef_mem[int'(band) * TERMS + int'(term)] = coef;
                    writes_taken++;
                end
                else
                begin
                    writes_dropped++;
                end
            end
            else
            begin
                pending_results.push_back(reconstruct(band, r, g, b));
                evals_taken++;
            end
        endfunction

        function void check_result(logic [BAND_W-1:0] band_out, logic [VALUE_W-1:0] value,
                                   logic sat);
            spectral_result_t want;
            if (pending_results.size() == 0)
            begin
                $error("result word with no evaluation outstanding: band_out %0d value %h",
                       band_out, value);
                mismatches++;
                return;
            end
            want = pending_results.pop_front();
            results_checked++;
            if (band_out !== want.band)
            begin
                $error("band_out: expected %0d, got %0d", want.band, band_out);
                mismatches++;
            end
            if (value !== want.value)
            begin
                $error("spectral_value: expected %0d, got %0d",
                       $signed(want.value), $signed(value));
                mismatches++;
            end
            if (sat !== want.sat)
            begin
                $error("saturated: expected %0d, got %0d", want.sat, sat);
                mismatches++;
            end
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [S_DATA_W-1:0] s_axis_tdata;
    logic                s_axis_tuser;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [M_DATA_W-1:0] m_axis_tdata;
    logic                m_axis_tuser;

    spectrum_scoreboard sb;
    int unsigned tx_idle_pct = 37;
    int unsigned rx_idle_pct = 83;
    int unsigned hold_req_count = 0;
    int unsigned hold_ack_count = 0;
    int unsigned hold_left = 0;
    int unsigned words_counted = 0;
    bit          band_ready [DEF_BANDS];
    int unsigned ready_bands [$];

    rgb_poly4_spectrum_eval u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Receiver: random stalls, plus a long hold whenever one is requested.
    always @(negedge clk)
    begin
        if (hold_req_count != hold_ack_count)
        begin
            hold_ack_count = hold_req_count;
            hold_left      = HOLD_CYCLES;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata[BAND_W-1:0], m_axis_tdata[BAND_W +: VALUE_W],
                            m_axis_tuser);
    end

    initial
    begin
        #16_000_000;
        $display("FAILURE");
        $finish;
    end

    function automatic logic [COEF_W-1:0] pick_coef(input int unsigned style);
        logic [COEF_W-1:0] r;
        r = $urandom();
        if (style == 4)
            style = ($urandom_range(9) < 8) ? $urandom_range(1) : $urandom_range(2, 3);
        case (style)
            1:       return {{7{r[24]}}, r[24:0]};
            2:       return COEF_MAX;
            3:       return COEF_MIN;
            default: return r;
        endcase
    endfunction

    function automatic logic [DEF_PIXEL_BITS-1:0] pick_sample();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 15)
            return '0;
        if (roll < 30)
            return PIX_MAX;
        return DEF_PIXEL_BITS'($urandom_range(32'(PIX_MAX)));
    endfunction

    task automatic send_word(input logic cmd, input logic [DEF_PIXEL_BITS-1:0] r,
                             input logic [DEF_PIXEL_BITS-1:0] g,
                             input logic [DEF_PIXEL_BITS-1:0] b,
                             input logic [BAND_W-1:0] band, input logic [TERM_W-1:0] term,
                             input logic [COEF_W-1:0] coef);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= S_DATA_W'({coef, term, band, b, g, r});
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_word(cmd, r, g, b, band, term, coef);
        if (cmd == CMD_EVAL || term < TERMS)
            words_counted++;
    endtask

    task automatic send_eval(input logic [BAND_W-1:0] band, input logic [DEF_PIXEL_BITS-1:0] r,
                             input logic [DEF_PIXEL_BITS-1:0] g,
                             input logic [DEF_PIXEL_BITS-1:0] b);
        send_word(CMD_EVAL, r, g, b, band, TERM_W'($urandom()), $urandom());
    endtask

    task automatic send_random_eval();
        send_eval(BAND_W'(ready_bands[$urandom_range(ready_bands.size() - 1)]),
                  pick_sample(), pick_sample(), pick_sample());
    endtask

    // All 36 terms of a band, in shuffled order; pixel fields carry noise.
    task automatic program_band(input logic [BAND_W-1:0] band, input int unsigned style);
        int unsigned order [TERMS];
        int unsigned j;
        int unsigned tmp;
        for (int i = 0; i < TERMS; i++)
            order[i] = i;
        for (int i = TERMS - 1; i > 0; i--)
        begin
            j        = $urandom_range(i);
            tmp      = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        for (int i = 0; i < TERMS; i++)
            send_word(CMD_WRITE, DEF_PIXEL_BITS'($urandom()), DEF_PIXEL_BITS'($urandom()),
                      DEF_PIXEL_BITS'($urandom()), band,
                      TERM_W'(order[i]), pick_coef(style));
        if (!band_ready[band])
        begin
            band_ready[band] = 1'b1;
            ready_bands.push_back(32'(band));
        end
    endtask

    task automatic sender_pause();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (sb.pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Receiver holds off while evaluations keep coming, so the block backs up.
    task automatic long_hold();
        hold_req_count++;
        repeat (6)
            send_random_eval();
        sender_pause();
    endtask

    initial
    begin
        int unsigned target;
        int unsigned roll;
        bit          hold_done;
        logic [BAND_W-1:0] band;
        sb = new();
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = CMD_WRITE;
        rst_n         = 1'b0;
        repeat (9)
            @(negedge clk);
        rst_n <= 1'b1;

        // Directed: extreme coefficients at the lowest and highest band.
        program_band('0, 2);
        program_band(BAND_W'(DEF_BANDS - 1), 3);
        send_eval('0, PIX_MAX, PIX_MAX, PIX_MAX);
        send_eval('0, '0, '0, '0);
        send_eval('0, PIX_MAX, '0, '0);
        send_eval('0, '0, PIX_MAX, '0);
        send_eval('0, '0, '0, PIX_MAX);
        send_eval('0, DEF_PIXEL_BITS'(1), DEF_PIXEL_BITS'(1), DEF_PIXEL_BITS'(1));
        send_eval('0, DEF_PIXEL_BITS'(128), DEF_PIXEL_BITS'(128), DEF_PIXEL_BITS'(128));
        send_eval(BAND_W'(DEF_BANDS - 1), PIX_MAX, PIX_MAX, PIX_MAX);
        send_eval(BAND_W'(DEF_BANDS - 1), '0, '0, '0);
        send_eval(BAND_W'(DEF_BANDS - 1), PIX_MAX, DEF_PIXEL_BITS'(1), DEF_PIXEL_BITS'(128));
        // Writes to terms past the end must leave the band untouched.
        send_word(CMD_WRITE, '0, '0, '0, '0, TERM_W'(TERMS), COEF_MIN);
        send_word(CMD_WRITE, PIX_MAX, PIX_MAX, PIX_MAX, '0, TERM_W'(TERM_MAX), '0);
        send_word(CMD_WRITE, '0, '0, '0, BAND_W'(DEF_BANDS - 1), TERM_W'(TERM_MAX), COEF_MAX);
        send_eval('0, PIX_MAX, PIX_MAX, PIX_MAX);
        send_eval(BAND_W'(DEF_BANDS - 1), PIX_MAX, PIX_MAX, PIX_MAX);
        // Single coefficient update, then back-to-back evaluations.
        send_word(CMD_WRITE, '0, '0, '0, '0, TERM_W'(TERMS - 1), '0);
        send_eval('0, PIX_MAX, PIX_MAX, PIX_MAX);
        send_eval('0, PIX_MAX, PIX_MAX, PIX_MAX);

        for (int phase = 0; phase < 3; phase++)
        begin
            tx_idle_pct = (phase == 0) ? 37 : (phase == 1) ? 83 : 0;
            rx_idle_pct = (phase == 0) ? 83 : (phase == 1) ? 37 : 0;
            target      = words_counted + PHASE_WORDS;
            hold_done   = 1'b0;
            while (words_counted < target)
            begin
                if (!hold_done && words_counted + PHASE_WORDS / 2 >= target)
                begin
                    long_hold();
                    hold_done = 1'b1;
                end
                roll = $urandom_range(99);
                if (ready_bands.size() < 4 || roll < 4)
                    program_band(BAND_W'($urandom_range(DEF_BANDS - 1)), $urandom_range(4));
                else if (roll < 16)
                begin
                    band = BAND_W'(ready_bands[$urandom_range(ready_bands.size() - 1)]);
                    send_word(CMD_WRITE, DEF_PIXEL_BITS'($urandom()),
                              DEF_PIXEL_BITS'($urandom()), DEF_PIXEL_BITS'($urandom()), band,
                              TERM_W'($urandom_range(TERMS - 1)), pick_coef(4));
                end
                else if (roll < 24)
                    send_word(CMD_WRITE, DEF_PIXEL_BITS'($urandom()),
                              DEF_PIXEL_BITS'($urandom()), DEF_PIXEL_BITS'($urandom()),
                              BAND_W'($urandom_range(DEF_BANDS - 1)),
                              TERM_W'($urandom_range(TERMS, TERM_MAX)),
                              $urandom());
                else
                    send_random_eval();
            end
            sender_pause();
        end

        repeat (END_CYCLES)
            @(posedge clk);
        if (sb.pending_results.size() != 0)
        begin
            $error("%0d evaluations never produced a result", sb.pending_results.size());
            sb.mismatches++;
        end
        $display("Checked %0d results of %0d evaluations over %0d programmed bands.",
                 sb.results_checked, sb.evals_taken, ready_bands.size());
        $display("Coefficient writes: %0d stored, %0d out-of-range terms dropped; %0s",
                 sb.writes_taken, sb.writes_dropped,
                 "stalls ran 37/83, 83/37 and 0/0 percent with a long receiver hold.");
        if (sb.mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
